@@ design/subpixel_quadratic_peak_fit_defines.svh @@
// Assertion macros used by the peak fit control module.
`ifndef SUBPIXEL_QUADRATIC_PEAK_FIT_DEFINES_SVH
`define SUBPIXEL_QUADRATIC_PEAK_FIT_DEFINES_SVH

// Checked only outside reset.
`define SQPF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define SQPF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ design/sqpf_pkg.sv @@
package sqpf_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int COEF_W        = 13;
    localparam int SPROD_W       = SAMPLE_W + COEF_W;
    localparam int FIT_W         = 40;
    localparam int PATCH_LEN     = 25;
    localparam int IDX_W         = 5;
    localparam int NUM_TERMS     = 5;
    localparam int NORM_BITS     = 28;
    localparam int TERM_W        = NORM_BITS + 1;
    localparam int PROD_W        = 2 * TERM_W;
    localparam int SOLVE_W       = 61;
    localparam int OUT_FRAC_BITS = 12;
    localparam int Q_W           = OUT_FRAC_BITS + 2;
    localparam int OUT_W         = OUT_FRAC_BITS + 3;
    localparam int DIV_STEPS     = Q_W;
    localparam int MUL_STEPS     = 6;
    localparam int CNT_W         = 4;

    localparam int TERM_A = 0;
    localparam int TERM_B = 1;
    localparam int TERM_C = 2;
    localparam int TERM_D = 3;
    localparam int TERM_E = 4;

    localparam logic signed [FIT_W-1:0] NORM_LIM = FIT_W'(2**NORM_BITS - 1);
    localparam logic signed [FIT_W-1:0] NORM_NEG = FIT_W'(-(2**NORM_BITS));

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef coef_t coef_set_t [NUM_TERMS];

    localparam coef_t QUAD_COEF [0:4] = '{
        13'sd1872, -13'sd936, -13'sd1872, -13'sd936, 13'sd1872
    };
    localparam coef_t LIN_COEF [0:4] = '{
        -13'sd2621, -13'sd1311, 13'sd0, 13'sd1311, 13'sd2621
    };
    localparam coef_t CROSS_COEF [0:4][0:4] = '{
        '{13'sd2621, 13'sd1311, 13'sd0, -13'sd1311, -13'sd2621},
        '{13'sd1311, 13'sd655, 13'sd0, -13'sd655, -13'sd1311},
        '{13'sd0, 13'sd0, 13'sd0, 13'sd0, 13'sd0},
        '{-13'sd1311, -13'sd655, 13'sd0, 13'sd655, 13'sd1311},
        '{-13'sd2621, -13'sd1311, 13'sd0, 13'sd1311, 13'sd2621}
    };

    localparam logic [2:0] XI_TAB [0:31] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd0, 3'd0
    };
    localparam logic [2:0] YI_TAB [0:31] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd0, 3'd0
    };

    function automatic coef_set_t sample_coefs(input logic [IDX_W-1:0] idx);
        logic [2:0] xi;
        logic [2:0] yi;
        coef_set_t  c;
        xi = XI_TAB[idx];
        yi = YI_TAB[idx];
        c[TERM_A] = QUAD_COEF[xi];
        c[TERM_B] = QUAD_COEF[yi];
        c[TERM_C] = LIN_COEF[xi];
        c[TERM_D] = LIN_COEF[yi];
        c[TERM_E] = CROSS_COEF[xi][yi];
        return c;
    endfunction

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_NORM,
        ST_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        PAIR_AB,
        PAIR_EE,
        PAIR_DE,
        PAIR_BC,
        PAIR_CE,
        PAIR_AD
    } pair_t;

    typedef struct packed {
        logic  acc_sample;
        logic  norm_shift;
        logic  mul_en;
        pair_t mul_pair;
        logic  acc_en;
        pair_t acc_pair;
        logic  div_init;
        logic  div_step;
        logic  load_out;
    } cmd_t;

    typedef struct packed {
        logic norm_big;
    } status_t;

endpackage

@@ design/subpixel_quadratic_peak_fit.sv @@
// Takes one patch sample per cycle while s_ready is high; a patch holds 25 samples.
// After the last transaction the result passes through normalization, the shared 29x29
// multiplier and the two radix-2 dividers, and is then loaded into the output register,
// which holds the result until taken. Input is stalled during the solve.
// Reset (aresetn, synchronous, active low) clears the fit terms, sample index and control.
module subpixel_quadratic_peak_fit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [sqpf_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                 s_last,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [sqpf_pkg::OUT_W-1:0]    m_offset_x,
    output logic signed [sqpf_pkg::OUT_W-1:0]    m_offset_y,
    output logic                                 m_rejected
);

    sqpf_pkg::cmd_t    cmd;
    sqpf_pkg::status_t status;

    sqpf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_last),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sqpf_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .s_sample   (s_sample),
        .m_offset_x (m_offset_x),
        .m_offset_y (m_offset_y),
        .m_rejected (m_rejected)
    );

endmodule

@@ design/sqpf_datapath.sv @@
module sqpf_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  sqpf_pkg::cmd_t                        cmd,
    output sqpf_pkg::status_t                     status,
    input  logic signed [sqpf_pkg::SAMPLE_W-1:0]  s_sample,
    output logic signed [sqpf_pkg::OUT_W-1:0]     m_offset_x,
    output logic signed [sqpf_pkg::OUT_W-1:0]     m_offset_y,
    output logic                                  m_rejected
);

    logic [sqpf_pkg::IDX_W-1:0]              idx_reg, idx_next;
    logic signed [sqpf_pkg::FIT_W-1:0]       terms_reg [sqpf_pkg::NUM_TERMS];
    logic signed [sqpf_pkg::FIT_W-1:0]       terms_next [sqpf_pkg::NUM_TERMS];
    logic [sqpf_pkg::NUM_TERMS-1:0]          lost_reg, lost_next;
    logic signed [sqpf_pkg::SPROD_W-1:0]     sprod [sqpf_pkg::NUM_TERMS];
    sqpf_pkg::coef_set_t                     coefs;
    logic                                    idx_open;

    logic signed [sqpf_pkg::TERM_W-1:0]      opa, opb;
    logic signed [sqpf_pkg::PROD_W-1:0]      prod_reg, prod_next;
    logic signed [sqpf_pkg::SOLVE_W-1:0]     prod_ext;
    logic signed [sqpf_pkg::SOLVE_W-1:0]     det_reg, det_next;
    logic signed [sqpf_pkg::SOLVE_W-1:0]     nx_reg, nx_next;
    logic signed [sqpf_pkg::SOLVE_W-1:0]     ny_reg, ny_next;

    logic [sqpf_pkg::SOLVE_W-1:0]            abs_det, abs_nx, abs_ny;
    logic [sqpf_pkg::SOLVE_W:0]              dvs_reg, dvs_next;
    logic [sqpf_pkg::SOLVE_W+1:0]            remx_reg, remx_next;
    logic [sqpf_pkg::SOLVE_W+1:0]            remy_reg, remy_next;
    logic [sqpf_pkg::SOLVE_W+1:0]            difx, dify;
    logic                                    bitx, bity;
    logic [sqpf_pkg::Q_W-1:0]                qx_reg, qx_next;
    logic [sqpf_pkg::Q_W-1:0]                qy_reg, qy_next;
    logic                                    negx_reg, negx_next;
    logic                                    negy_reg, negy_next;
    logic                                    rej_reg, rej_next;

    logic signed [sqpf_pkg::OUT_W-1:0]       ox_reg, ox_next;
    logic signed [sqpf_pkg::OUT_W-1:0]       oy_reg, oy_next;
    logic                                    orej_reg, orej_next;

    always_comb begin
        coefs    = sqpf_pkg::sample_coefs(idx_reg);
        idx_open = idx_reg < sqpf_pkg::IDX_W'(sqpf_pkg::PATCH_LEN);
        idx_next = idx_reg;
        if (cmd.load_out) begin
            idx_next = '0;
        end else if (cmd.acc_sample && idx_open) begin
            idx_next = idx_reg + 1'b1;
        end
        status.norm_big = 1'b0;
        for (int i = 0; i < sqpf_pkg::NUM_TERMS; i++) begin
            sprod[i] = s_sample * coefs[i];
            terms_next[i] = terms_reg[i];
            lost_next[i]  = lost_reg[i];
            if (cmd.load_out) begin
                terms_next[i] = '0;
                lost_next[i]  = 1'b0;
            end else if (cmd.acc_sample && idx_open) begin
                terms_next[i] = terms_reg[i]
                    + {{(sqpf_pkg::FIT_W - sqpf_pkg::SPROD_W){sprod[i][sqpf_pkg::SPROD_W-1]}},
                       sprod[i]};
            end else if (cmd.norm_shift) begin
                terms_next[i] = terms_reg[i] >>> 1;
                lost_next[i]  = lost_reg[i] | terms_reg[i][0];
            end
            // A negative term resting exactly on the lower limit still needs a shift
            // unless nonzero bits were already shifted out, so the count follows the
            // magnitude of the unshifted term.
            if ((terms_reg[i] > sqpf_pkg::NORM_LIM) || (terms_reg[i] < sqpf_pkg::NORM_NEG)
                || ((terms_reg[i] == sqpf_pkg::NORM_NEG) && !lost_reg[i])) begin
                status.norm_big = 1'b1;
            end
        end
    end

    always_comb begin
        opa = '0;
        opb = '0;
        unique case (cmd.mul_pair)
            sqpf_pkg::PAIR_AB: begin
                opa = $signed(terms_reg[sqpf_pkg::TERM_A][sqpf_pkg::TERM_W-1:0]);
                opb = $signed(terms_reg[sqpf_pkg::TERM_B][sqpf_pkg::TERM_W-1:0]);
            end
            sqpf_pkg::PAIR_EE: begin
                opa = $signed(terms_reg[sqpf_pkg::TERM_E][sqpf_pkg::TERM_W-1:0]);
                opb = $signed(terms_reg[sqpf_pkg::TERM_E][sqpf_pkg::TERM_W-1:0]);
            end
            sqpf_pkg::PAIR_DE: begin
                opa = $signed(terms_reg[sqpf_pkg::TERM_D][sqpf_pkg::TERM_W-1:0]);
                opb = $signed(terms_reg[sqpf_pkg::TERM_E][sqpf_pkg::TERM_W-1:0]);
            end
            sqpf_pkg::PAIR_BC: begin
                opa = $signed(terms_reg[sqpf_pkg::TERM_B][sqpf_pkg::TERM_W-1:0]);
                opb = $signed(terms_reg[sqpf_pkg::TERM_C][sqpf_pkg::TERM_W-1:0]);
            end
            sqpf_pkg::PAIR_CE: begin
                opa = $signed(terms_reg[sqpf_pkg::TERM_C][sqpf_pkg::TERM_W-1:0]);
                opb = $signed(terms_reg[sqpf_pkg::TERM_E][sqpf_pkg::TERM_W-1:0]);
            end
            sqpf_pkg::PAIR_AD: begin
                opa = $signed(terms_reg[sqpf_pkg::TERM_A][sqpf_pkg::TERM_W-1:0]);
                opb = $signed(terms_reg[sqpf_pkg::TERM_D][sqpf_pkg::TERM_W-1:0]);
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
        prod_next = cmd.mul_en ? opa * opb : prod_reg;
    end

    always_comb begin
        prod_ext = {{(sqpf_pkg::SOLVE_W - sqpf_pkg::PROD_W){prod_reg[sqpf_pkg::PROD_W-1]}},
                    prod_reg};
        det_next = det_reg;
        nx_next  = nx_reg;
        ny_next  = ny_reg;
        if (cmd.acc_en) begin
            case (cmd.acc_pair)
                sqpf_pkg::PAIR_AB: det_next = prod_ext <<< 2;
                sqpf_pkg::PAIR_EE: det_next = det_reg - prod_ext;
                sqpf_pkg::PAIR_DE: nx_next  = prod_ext;
                sqpf_pkg::PAIR_BC: nx_next  = nx_reg - (prod_ext <<< 1);
                sqpf_pkg::PAIR_CE: ny_next  = prod_ext;
                sqpf_pkg::PAIR_AD: ny_next  = ny_reg - (prod_ext <<< 1);
                default: det_next = det_reg;
            endcase
        end
    end

    always_comb begin
        abs_det = det_reg[sqpf_pkg::SOLVE_W-1] ? -det_reg : det_reg;
        abs_nx  = nx_reg[sqpf_pkg::SOLVE_W-1] ? -nx_reg : nx_reg;
        abs_ny  = ny_reg[sqpf_pkg::SOLVE_W-1] ? -ny_reg : ny_reg;
        difx    = remx_reg - {1'b0, dvs_reg};
        dify    = remy_reg - {1'b0, dvs_reg};
        bitx    = remx_reg >= {1'b0, dvs_reg};
        bity    = remy_reg >= {1'b0, dvs_reg};
        dvs_next  = dvs_reg;
        remx_next = remx_reg;
        remy_next = remy_reg;
        qx_next   = qx_reg;
        qy_next   = qy_reg;
        negx_next = negx_reg;
        negy_next = negy_reg;
        rej_next  = rej_reg;
        if (cmd.div_init) begin
            dvs_next  = {abs_det, 1'b0};
            remx_next = {2'b00, abs_nx};
            remy_next = {2'b00, abs_ny};
            qx_next   = '0;
            qy_next   = '0;
            negx_next = nx_reg[sqpf_pkg::SOLVE_W-1] ^ det_reg[sqpf_pkg::SOLVE_W-1];
            negy_next = ny_reg[sqpf_pkg::SOLVE_W-1] ^ det_reg[sqpf_pkg::SOLVE_W-1];
            rej_next  = (det_reg == '0) || ({1'b0, abs_nx} > {abs_det, 1'b0})
                        || ({1'b0, abs_ny} > {abs_det, 1'b0});
        end else if (cmd.div_step) begin
            remx_next = bitx ? {difx[sqpf_pkg::SOLVE_W:0], 1'b0}
                             : {remx_reg[sqpf_pkg::SOLVE_W:0], 1'b0};
            remy_next = bity ? {dify[sqpf_pkg::SOLVE_W:0], 1'b0}
                             : {remy_reg[sqpf_pkg::SOLVE_W:0], 1'b0};
            qx_next   = {qx_reg[sqpf_pkg::Q_W-2:0], bitx};
            qy_next   = {qy_reg[sqpf_pkg::Q_W-2:0], bity};
        end
        ox_next   = ox_reg;
        oy_next   = oy_reg;
        orej_next = orej_reg;
        if (cmd.load_out) begin
            orej_next = rej_reg;
            if (rej_reg) begin
                ox_next = '0;
                oy_next = '0;
            end else begin
                ox_next = negx_reg ? -$signed({1'b0, qx_reg}) : $signed({1'b0, qx_reg});
                oy_next = negy_reg ? -$signed({1'b0, qy_reg}) : $signed({1'b0, qy_reg});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            lost_reg <= '0;
            for (int i = 0; i < sqpf_pkg::NUM_TERMS; i++) begin
                terms_reg[i] <= '0;
            end
        end else begin
            idx_reg  <= idx_next;
            lost_reg <= lost_next;
            for (int i = 0; i < sqpf_pkg::NUM_TERMS; i++) begin
                terms_reg[i] <= terms_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        det_reg  <= det_next;
        nx_reg   <= nx_next;
        ny_reg   <= ny_next;
        dvs_reg  <= dvs_next;
        remx_reg <= remx_next;
        remy_reg <= remy_next;
        qx_reg   <= qx_next;
        qy_reg   <= qy_next;
        negx_reg <= negx_next;
        negy_reg <= negy_next;
        rej_reg  <= rej_next;
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        orej_reg <= orej_next;
    end

    assign m_offset_x = ox_reg;
    assign m_offset_y = oy_reg;
    assign m_rejected = orej_reg;

endmodule

@@ design/sqpf_ctrl.sv @@
`include "subpixel_quadratic_peak_fit_defines.svh"

module sqpf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_last,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  sqpf_pkg::status_t status,
    output sqpf_pkg::cmd_t    cmd
);

    sqpf_pkg::state_t           state_reg, state_next;
    logic [sqpf_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       valid_reg, valid_next;
    logic                       out_free;

    assign out_free = !valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            sqpf_pkg::ST_ACCUM: begin
                if (s_valid && s_last) begin
                    state_next = sqpf_pkg::ST_NORM;
                end
            end
            sqpf_pkg::ST_NORM: begin
                if (!status.norm_big) begin
                    state_next = sqpf_pkg::ST_MUL;
                    cnt_next   = '0;
                end
            end
            sqpf_pkg::ST_MUL: begin
                if (cnt_reg == sqpf_pkg::CNT_W'(sqpf_pkg::MUL_STEPS)) begin
                    state_next = sqpf_pkg::ST_DIV_INIT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            sqpf_pkg::ST_DIV_INIT: begin
                state_next = sqpf_pkg::ST_DIV;
                cnt_next   = '0;
            end
            sqpf_pkg::ST_DIV: begin
                if (cnt_reg == sqpf_pkg::CNT_W'(sqpf_pkg::DIV_STEPS - 1)) begin
                    state_next = sqpf_pkg::ST_DONE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            sqpf_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = sqpf_pkg::ST_ACCUM;
                end
            end
            default: state_next = sqpf_pkg::ST_ACCUM;
        endcase
    end

    always_comb begin
        cmd            = '0;
        cmd.mul_pair   = sqpf_pkg::pair_t'(cnt_reg[2:0]);
        cmd.acc_pair   = sqpf_pkg::pair_t'(cnt_reg[2:0] - 3'd1);
        s_ready        = 1'b0;
        unique case (state_reg)
            sqpf_pkg::ST_ACCUM: begin
                s_ready        = 1'b1;
                cmd.acc_sample = s_valid;
            end
            sqpf_pkg::ST_NORM: begin
                cmd.norm_shift = status.norm_big;
            end
            sqpf_pkg::ST_MUL: begin
                cmd.mul_en = cnt_reg < sqpf_pkg::CNT_W'(sqpf_pkg::MUL_STEPS);
                cmd.acc_en = cnt_reg != '0;
            end
            sqpf_pkg::ST_DIV_INIT: begin
                cmd.div_init = 1'b1;
            end
            sqpf_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            sqpf_pkg::ST_DONE: begin
                cmd.load_out = out_free;
            end
            default: s_ready = 1'b0;
        endcase
        if (cmd.load_out) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sqpf_pkg::ST_ACCUM;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    assign m_valid = valid_reg;

    `SQPF_ASSERT(a_last_starts_solve, s_valid && s_ready && s_last |=> state_reg == sqpf_pkg::ST_NORM, "last transaction did not start the solve")
    `SQPF_ASSERT(a_load_sets_valid, cmd.load_out |=> m_valid, "loaded result is not presented")
    `SQPF_ASSERT(a_div_count_range, state_reg == sqpf_pkg::ST_DIV |-> cnt_reg < sqpf_pkg::CNT_W'(sqpf_pkg::DIV_STEPS), "divider step count out of range")
    `SQPF_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> state_reg == sqpf_pkg::ST_ACCUM && !m_valid, "reset did not clear control state")

endmodule
